@@ rtl/fir_pkg.sv @@
// Shared constants, types and helpers for the cell-chain FIR filter.
`timescale 1ns / 1ps

package fir_pkg;

  // Filter size and field widths.
  localparam int MAX_TAPS  = 32;
  localparam int TAP_W     = $clog2(MAX_TAPS);
  localparam int SAMPLE_W  = 16;
  localparam int COEFF_W   = 16;
  localparam int IDX_W     = 5;
  localparam int CFG_W     = 6;
  localparam int OP_W      = 2;
  localparam int PROD_W    = SAMPLE_W + COEFF_W;
  localparam int ACC_W     = PROD_W + TAP_W;
  localparam int FRAC_BITS = 15;

  // Stream payload layout.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  typedef logic [OP_W-1:0]  opcode_t;
  typedef logic [TAP_W-1:0] tap_idx_t;

  // Request opcodes.
  localparam opcode_t OP_FILTER = 2'd0;
  localparam opcode_t OP_LOAD   = 2'd1;
  localparam opcode_t OP_CLEAR  = 2'd2;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic                       shift;
    logic                       clear;
    logic                       rotate;
    logic                       load;
    tap_idx_t                   load_cell;
    tap_idx_t                   top_idx;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [COEFF_W-1:0]  coeff;
  } cell_ctrl_t;

  // Index of the highest tap in use, with the tap count clamped to 1..MAX_TAPS.
  function automatic tap_idx_t top_from_count(logic [CFG_W-1:0] count);
    tap_idx_t r;
    if (count == '0) begin
      r = '0;
    end else if (int'(count) > MAX_TAPS) begin
      r = tap_idx_t'(MAX_TAPS - 1);
    end else begin
      r = tap_idx_t'(count - 1'b1);
    end
    return r;
  endfunction

endpackage

@@ rtl/fir_cell.sv @@
// One cell of the FIR chain: a delay-line sample, a coefficient and a partial sum.
`timescale 1ns / 1ps

module fir_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fir_pkg::cell_ctrl_t                 ctrl,
  input  fir_pkg::tap_idx_t                   cell_idx,
  input  logic signed [fir_pkg::SAMPLE_W-1:0] sample_prev,
  input  logic signed [fir_pkg::COEFF_W-1:0]  coeff_prev,
  input  logic signed [fir_pkg::ACC_W-1:0]    acc_above,
  output logic signed [fir_pkg::SAMPLE_W-1:0] sample_o,
  output logic signed [fir_pkg::COEFF_W-1:0]  coeff_o,
  output logic signed [fir_pkg::ACC_W-1:0]    acc_o
);
  import fir_pkg::*;

  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic signed [COEFF_W-1:0]  coeff_r, coeff_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc_in;

  // Product of this tap and the partial sum handed down from the cell above.
  always_comb begin
    prod    = sample_r * coeff_r;
    acc_in  = (cell_idx == ctrl.top_idx) ? '0 : acc_above;
    acc_nxt = acc_in + ACC_W'(prod);
  end

  // The delay line shifts one cell per new sample and clears as a whole.
  always_comb begin
    priority if (ctrl.clear) begin
      sample_nxt = '0;
    end else if (ctrl.shift) begin
      sample_nxt = sample_prev;
    end else begin
      sample_nxt = sample_r;
    end
  end

  // Coefficients are written in place or rotate around the ring.
  always_comb begin
    priority if (ctrl.load && (cell_idx == ctrl.load_cell)) begin
      coeff_nxt = ctrl.coeff;
    end else if (ctrl.rotate) begin
      coeff_nxt = coeff_prev;
    end else begin
      coeff_nxt = coeff_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      coeff_r  <= '0;
    end else begin
      sample_r <= sample_nxt;
      coeff_r  <= coeff_nxt;
    end
  end

  // The partial sum runs freely; the sequencer decides when it is complete.
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign sample_o = sample_r;
  assign coeff_o  = coeff_r;
  assign acc_o    = acc_r;

endmodule

@@ rtl/fir_out.sv @@
// Output stage: rounding, saturation and the result register of the FIR filter.
`timescale 1ns / 1ps

module fir_out (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  logic signed [fir_pkg::ACC_W-1:0]    acc,
  input  logic                                out_ready,
  output logic                                free,
  output logic                                out_valid,
  output logic signed [fir_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                saturated
);
  import fir_pkg::*;

  localparam int Y_W        = ACC_W + 1 - FRAC_BITS;
  localparam int SAMPLE_MAX = 2 ** (SAMPLE_W - 1) - 1;
  localparam int SAMPLE_MIN = -(2 ** (SAMPLE_W - 1));
  localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(SAMPLE_MAX);
  localparam logic signed [Y_W-1:0] Y_MIN = Y_W'(SAMPLE_MIN);

  logic                       valid_r, valid_nxt;
  logic signed [SAMPLE_W-1:0] data_r, data_nxt;
  logic                       sat_r, sat_nxt;
  logic        [ACC_W:0]      biased;
  logic signed [Y_W-1:0]      y;

  // Add half an LSB, then drop the fraction bits (floor), so halves round up.
  always_comb begin
    biased = {acc[ACC_W-1], acc} + (ACC_W + 1)'(2 ** (FRAC_BITS - 1));
    y      = biased[ACC_W:FRAC_BITS];
  end

  // Clip to the sample range and flag the clip.
  always_comb begin
    data_nxt  = data_r;
    sat_nxt   = sat_r;
    valid_nxt = valid_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
      priority if (y > Y_MAX) begin
        data_nxt = SAMPLE_W'(SAMPLE_MAX);
        sat_nxt  = 1'b1;
      end else if (y < Y_MIN) begin
        data_nxt = SAMPLE_W'(SAMPLE_MIN);
        sat_nxt  = 1'b1;
      end else begin
        data_nxt = y[SAMPLE_W-1:0];
        sat_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    sat_r  <= sat_nxt;
  end

  assign free       = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign sample_out = data_r;
  assign saturated  = sat_r;

endmodule

@@ rtl/fir_filter.sv @@
// Top level of the streaming FIR filter: request decode, sequencer and cell chain.
//
// Input requests arrive on the in_ stream. in_tuser carries the opcode: filter
// a sample, load one coefficient, or clear the delay line. A filter request
// yields one result on the out_ stream; load and clear yield none and leave the
// filter idle. The tap count is written on the cfg_ port, which is ready only
// while the filter is idle.
// Each filter request steps through the sequencer in order: the sample shifts in
// on acceptance, ST_ALIGN checks and rotates the coefficient ring, ST_COMPUTE lets
// the partial sum ripple down the cell chain, and ST_DONE loads the result into
// the output register once it is free; then the next request can be accepted.
// After a tap count change the first sample waits in ST_ALIGN while the
// coefficient ring rotates into its new alignment.
// Reset clears the coefficients and the delay line and sets the tap count to
// one. If the receiver stalls, the result waits in the output register; the
// next request is still taken, and its result waits in the chain until the
// output register frees.
`timescale 1ns / 1ps

module fir_filter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata, from bit 0: sample_in[15:0], coeff_index[20:16], coeff_value[36:21].
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [fir_pkg::IN_DATA_W-1:0]        in_tdata,
  // in_tuser, from bit 0: opcode[1:0].
  input  logic [fir_pkg::OP_W-1:0]             in_tuser,
  // out_tdata, from bit 0: sample_out[15:0].
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [fir_pkg::OUT_DATA_W-1:0]       out_tdata,
  // out_tuser, from bit 0: saturated.
  output logic                                 out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fir_pkg::CFG_W-1:0]            cfg_data
);
  import fir_pkg::*;

  localparam int LC_W = ((TAP_W > IDX_W) ? TAP_W : IDX_W) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_COMPUTE,
    ST_DONE
  } state_t;

  state_t           state_r, state_nxt;
  tap_idx_t         off_r, off_nxt;
  tap_idx_t         cnt_r, cnt_nxt;
  logic [CFG_W-1:0] tap_count_r, tap_count_nxt;

  cell_ctrl_t       ctrl;
  tap_idx_t         top_idx;
  logic             in_fire;
  opcode_t          opcode;
  logic [IDX_W-1:0] coeff_index;
  logic [LC_W-1:0]  off_ext, idx_ext, cell_diff;
  logic             slot_ok;
  logic             out_free;
  logic             out_load;
  logic signed [SAMPLE_W-1:0] sample_out;

  logic signed [SAMPLE_W-1:0] sample_q [MAX_TAPS];
  logic signed [COEFF_W-1:0]  coeff_q  [MAX_TAPS];
  logic signed [ACC_W-1:0]    acc_q    [MAX_TAPS];

  // Request fields.
  assign opcode      = in_tuser;
  assign coeff_index = in_tdata[20:16];
  assign in_fire     = in_tvalid && in_tready;
  assign in_tready   = (state_r == ST_IDLE);
  assign cfg_ready   = (state_r == ST_IDLE);
  assign top_idx     = top_from_count(tap_count_r);

  // Cell holding a coefficient slot: the ring stores slot (off - cell) mod MAX_TAPS.
  always_comb begin
    off_ext   = LC_W'(off_r);
    idx_ext   = LC_W'(coeff_index);
    slot_ok   = (idx_ext < LC_W'(MAX_TAPS));
    cell_diff = (off_ext >= idx_ext) ? (off_ext - idx_ext)
                                     : (off_ext + LC_W'(MAX_TAPS) - idx_ext);
  end

  // Broadcast control to the chain.
  always_comb begin
    ctrl           = '0;
    ctrl.top_idx   = top_idx;
    ctrl.load_cell = cell_diff[TAP_W-1:0];
    ctrl.sample    = in_tdata[15:0];
    ctrl.coeff     = in_tdata[36:21];
    if (in_fire) begin
      ctrl.shift = (opcode == OP_FILTER);
      ctrl.load  = (opcode == OP_LOAD) && slot_ok;
      ctrl.clear = (opcode == OP_CLEAR);
    end
    ctrl.rotate = (state_r == ST_ALIGN) && (off_r != top_idx);
  end

  // Sequencer: align the coefficient ring, let the sum ripple, hand off the result.
  always_comb begin
    state_nxt     = state_r;
    off_nxt       = off_r;
    cnt_nxt       = cnt_r;
    tap_count_nxt = tap_count_r;
    out_load      = 1'b0;
    if (cfg_valid && cfg_ready) begin
      tap_count_nxt = cfg_data;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (opcode == OP_FILTER)) begin
          state_nxt = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (off_r == top_idx) begin
          state_nxt = ST_COMPUTE;
          cnt_nxt   = '0;
        end else if (off_r == tap_idx_t'(MAX_TAPS - 1)) begin
          off_nxt = '0;
        end else begin
          off_nxt = off_r + 1'b1;
        end
      end
      ST_COMPUTE: begin
        if (cnt_r == top_idx) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      off_r       <= '0;
      cnt_r       <= '0;
      tap_count_r <= CFG_W'(1);
    end else begin
      state_r     <= state_nxt;
      off_r       <= off_nxt;
      cnt_r       <= cnt_nxt;
      tap_count_r <= tap_count_nxt;
    end
  end

  // Cell chain: samples move up, coefficients rotate up, partial sums move down.
  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    logic signed [SAMPLE_W-1:0] sample_prev;
    logic signed [ACC_W-1:0]    acc_above;

    if (i == 0) begin : g_first
      assign sample_prev = ctrl.sample;
    end else begin : g_rest
      assign sample_prev = sample_q[i-1];
    end

    if (i == MAX_TAPS - 1) begin : g_top
      assign acc_above = '0;
    end else begin : g_below
      assign acc_above = acc_q[i+1];
    end

    fir_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .cell_idx    (tap_idx_t'(i)),
      .sample_prev (sample_prev),
      .coeff_prev  (coeff_q[(i + MAX_TAPS - 1) % MAX_TAPS]),
      .acc_above   (acc_above),
      .sample_o    (sample_q[i]),
      .coeff_o     (coeff_q[i]),
      .acc_o       (acc_q[i])
    );
  end

  // Rounding, saturation and the result register.
  fir_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .acc        (acc_q[0]),
    .out_ready  (out_tready),
    .free       (out_free),
    .out_valid  (out_tvalid),
    .sample_out (sample_out),
    .saturated  (out_tuser)
  );

  assign out_tdata = OUT_DATA_W'(sample_out);

  // A filter request closes the input once it has been accepted.
  a_busy_after_filter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_FILTER)) |=> !in_tready)
    else $error("input still open after a filter request");

  // The sum only ripples with the coefficient ring in its final alignment.
  a_aligned_compute: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMPUTE) |-> (off_r == top_idx))
    else $error("accumulating with a misaligned coefficient ring");

  // The ripple counter never passes the highest tap in use.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMPUTE) |-> (cnt_r <= top_idx))
    else $error("ripple counter beyond the tap count");

  // A new result appears only after the sequencer finished a sum.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == ST_DONE))
    else $error("result appeared without a finished sum");

endmodule
